// File: design/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types and constants of the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int MAX_SYMBOLS     = 64;
    localparam int FREQ_WIDTH      = 16;
    localparam int SYM_W           = 8;
    localparam int FREQ_W          = 16;
    localparam int CODE_W          = 63;
    localparam int CLEN_W          = 6;
    localparam int WBITS_W         = 22;
    localparam int TOTAL_W         = 28;
    localparam int HDR_W           = 10;
    localparam int TREE_W          = 6;
    localparam int BITS_PER_SYMBOL = 8;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [FREQ_W-1:0] frequency;
        logic              final_symbol;
    } t_in_beat;

    typedef struct packed {
        logic [SYM_W-1:0]   symbol_res;
        logic [FREQ_W-1:0]  frequency_res;
        logic [CODE_W-1:0]  code_bits;
        logic [CLEN_W-1:0]  code_length;
        logic [WBITS_W-1:0] weighted_bits;
        logic [TOTAL_W-1:0] total_bits;
        logic [HDR_W-1:0]   header_bits;
        logic [TREE_W-1:0]  tree_bits;
        logic [TOTAL_W-1:0] encoded_size;
        logic               end_of_table;
    } t_out_beat;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [FREQ_W-1:0] frequency;
    } t_entry;

    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic [CLEN_W-1:0] code_length;
    } t_code;

endpackage

// File: design/hcb_sort.sv
// ----------------------------------------------------------------------------
// hcb_sort
// Symbol table with load port and in-place exchange sort on frequency.
// ----------------------------------------------------------------------------
module hcb_sort #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS,
    localparam int IW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1,
    localparam int CW = $clog2(MAX_SYMBOLS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [IW-1:0]       i_wr_addr,
    input  hcb_pkg::t_entry     i_wr_data,
    input  logic                i_start,
    input  logic [CW-1:0]       i_count,
    output logic                o_busy,
    input  logic [IW-1:0]       i_rd_addr,
    output hcb_pkg::t_entry     o_rd_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDI  = 3'd1;
    localparam logic [2:0] S_LDI  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    hcb_pkg::t_entry r_mem [MAX_SYMBOLS];
    hcb_pkg::t_entry r_rd;
    hcb_pkg::t_entry r_a, n_a;
    logic [2:0]      r_st, n_st;
    logic [IW-1:0]   r_i, n_i, r_j, n_j;
    logic [CW-1:0]   r_n, n_n;
    logic [CW-1:0]   w_nm1;
    logic [IW-1:0]   w_inc_i;
    logic            w_we;
    logic [IW-1:0]   w_waddr, w_raddr;
    hcb_pkg::t_entry w_wdata;

    assign w_nm1   = r_n - CW'(1);
    assign w_inc_i = r_i + IW'(1);

    always_comb begin
        n_st    = r_st;
        n_i     = r_i;
        n_j     = r_j;
        n_n     = r_n;
        n_a     = r_a;
        w_we    = i_wr_en;
        w_waddr = i_wr_addr;
        w_wdata = i_wr_data;
        w_raddr = i_rd_addr;
        case (r_st)
            S_IDLE: begin
                if (i_start) begin
                    n_n = i_count;
                    n_i = '0;
                    if (i_count > CW'(1)) begin
                        n_st = S_RDI;
                    end
                end
            end
            S_RDI: begin
                w_raddr = r_i;
                n_st    = S_LDI;
            end
            S_LDI: begin
                n_a     = r_rd;
                n_j     = w_inc_i;
                w_raddr = w_inc_i;
                n_st    = S_CMP;
            end
            S_CMP: begin
                if (r_rd.frequency < r_a.frequency) begin
                    w_we    = 1'b1;
                    w_waddr = r_j;
                    w_wdata = r_a;
                    n_a     = r_rd;
                end
                if (r_j == w_nm1[IW-1:0]) begin
                    n_st = S_WB;
                end else begin
                    n_j     = r_j + IW'(1);
                    w_raddr = r_j + IW'(1);
                end
            end
            S_WB: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_a;
                if (w_inc_i == w_nm1[IW-1:0]) begin
                    n_st = S_IDLE;
                end else begin
                    n_i  = w_inc_i;
                    n_st = S_RDI;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_i <= n_i;
        r_j <= n_j;
        r_n <= n_n;
        r_a <= n_a;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    assign o_busy    = (r_st != S_IDLE);
    assign o_rd_data = r_rd;

    a_cmp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_CMP) |-> (r_j > r_i))
        else $error("sort inner index not above outer index");

endmodule

// File: design/hcb_merge.sv
// ----------------------------------------------------------------------------
// hcb_merge
// Node store and merge sequencer: picks the two least nodes, extends the
// leaf codes and joins the node strings until one node remains.
// ----------------------------------------------------------------------------
module hcb_merge #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS,
    localparam int IW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1,
    localparam int CW = $clog2(MAX_SYMBOLS + 1),
    localparam int WW = hcb_pkg::FREQ_W + CW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CW-1:0]     i_count,
    output logic              o_busy,
    output logic [IW-1:0]     o_tab_addr,
    input  hcb_pkg::t_entry   i_tab_data,
    input  logic [IW-1:0]     i_code_addr,
    output hcb_pkg::t_code    o_code
);

    localparam logic [3:0] M_IDLE = 4'd0;
    localparam logic [3:0] M_INIT = 4'd1;
    localparam logic [3:0] M_SCAN = 4'd2;
    localparam logic [3:0] M_NLD  = 4'd3;
    localparam logic [3:0] M_WCMP = 4'd4;
    localparam logic [3:0] M_CH   = 4'd5;
    localparam logic [3:0] M_RES  = 4'd6;
    localparam logic [3:0] M_PS   = 4'd7;
    localparam logic [3:0] M_PC   = 4'd8;
    localparam logic [3:0] M_PW   = 4'd9;
    localparam logic [3:0] M_CR   = 4'd10;
    localparam logic [3:0] M_CW   = 4'd11;
    localparam logic [3:0] M_UPD  = 4'd12;

    typedef struct packed {
        logic [hcb_pkg::SYM_W-1:0] ch;
        logic [IW-1:0]             leaf;
    } t_str_ent;

    logic [WW-1:0]  r_wmem [MAX_SYMBOLS];
    logic [CW-1:0]  r_lmem [MAX_SYMBOLS];
    t_str_ent       r_smem [2**(2*IW)];
    hcb_pkg::t_code r_cmem [MAX_SYMBOLS];

    logic [WW-1:0]  r_wq;
    logic [CW-1:0]  r_lq;
    t_str_ent       r_sa, r_sb;
    hcb_pkg::t_code r_cq;

    logic [3:0]             r_st;
    logic [CW-1:0]          r_n, r_k, r_i, r_live;
    logic [MAX_SYMBOLS-1:0] r_alive;
    logic [IW-1:0]          r_first, r_second, r_leaf, r_ini_idx;
    logic                   r_fv, r_sv, r_tsec, r_less, r_bit, r_ini_v;
    logic [WW-1:0]          r_fw, r_sw, r_cw;
    logic [CW-1:0]          r_fl, r_sl, r_cl;

    logic [WW-1:0]  w_tw;
    logic [CW-1:0]  w_tl, w_m, w_plen, w_k1;
    logic [IW-1:0]  w_tidx, w_pnode, w_ka, w_caddr;
    logic [IW-1:0]  w_na, w_nb;
    logic           w_s_we, w_wl_we, w_c_we;
    logic [2*IW-1:0] w_s_waddr;
    t_str_ent       w_s_wdata;
    logic [IW-1:0]  w_wl_addr, w_c_waddr;
    logic [WW-1:0]  w_w_wdata;
    logic [CW-1:0]  w_l_wdata;
    hcb_pkg::t_code w_c_wdata;

    assign w_tw    = r_tsec ? r_sw : r_fw;
    assign w_tl    = r_tsec ? r_sl : r_fl;
    assign w_tidx  = r_tsec ? r_second : r_first;
    assign w_m     = (r_cl < w_tl) ? r_cl : w_tl;
    assign w_pnode = r_bit ? r_second : r_first;
    assign w_plen  = r_bit ? r_sl : r_fl;
    assign w_k1    = r_k + CW'(1);

    // string and code read addresses
    always_comb begin
        w_ka = r_k[IW-1:0];
        w_na = r_i[IW-1:0];
        case (r_st)
            M_WCMP:  w_ka = '0;
            M_CH:    w_ka = w_k1[IW-1:0];
            M_PS:    w_na = w_pnode;
            M_CR:    w_na = r_second;
            default: w_ka = r_k[IW-1:0];
        endcase
        w_nb    = w_tidx;
        w_caddr = (r_st == M_PC) ? r_sa.leaf : i_code_addr;
    end

    // write ports
    always_comb begin
        w_s_we    = 1'b0;
        w_s_waddr = {r_ini_idx, IW'(0)};
        w_s_wdata = '{ch: i_tab_data.symbol, leaf: r_ini_idx};
        w_wl_we   = 1'b0;
        w_wl_addr = r_ini_idx;
        w_w_wdata = WW'(i_tab_data.frequency);
        w_l_wdata = CW'(1);
        w_c_we    = 1'b0;
        w_c_waddr = r_ini_idx;
        w_c_wdata = '0;
        case (r_st)
            M_INIT: begin
                w_s_we  = r_ini_v;
                w_wl_we = r_ini_v;
                w_c_we  = r_ini_v;
            end
            M_PW: begin
                w_c_we    = (r_cq.code_length < hcb_pkg::CLEN_W'(hcb_pkg::CODE_W));
                w_c_waddr = r_leaf;
                w_c_wdata.code_bits   = r_cq.code_bits
                                        | (hcb_pkg::CODE_W'(r_bit) << r_cq.code_length);
                w_c_wdata.code_length = r_cq.code_length + hcb_pkg::CLEN_W'(1);
            end
            M_CW: begin
                w_s_we    = 1'b1;
                w_s_waddr = {r_first, IW'(r_fl + r_k)};
                w_s_wdata = r_sa;
            end
            M_UPD: begin
                w_wl_we   = 1'b1;
                w_wl_addr = r_first;
                w_w_wdata = r_fw + r_sw;
                w_l_wdata = r_fl + r_sl;
            end
            default: w_s_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wl_we) begin
            r_wmem[w_wl_addr] <= w_w_wdata;
            r_lmem[w_wl_addr] <= w_l_wdata;
        end
        if (w_s_we) begin
            r_smem[w_s_waddr] <= w_s_wdata;
        end
        if (w_c_we) begin
            r_cmem[w_c_waddr] <= w_c_wdata;
        end
        r_wq <= r_wmem[r_i[IW-1:0]];
        r_lq <= r_lmem[r_i[IW-1:0]];
        r_sa <= r_smem[{w_na, w_ka}];
        r_sb <= r_smem[{w_nb, w_ka}];
        r_cq <= r_cmem[w_caddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= M_IDLE;
            r_ini_v <= 1'b0;
            r_alive <= '0;
        end else begin
            case (r_st)
                M_IDLE: begin
                    if (i_start) begin
                        r_n     <= i_count;
                        r_live  <= i_count;
                        r_k     <= '0;
                        r_ini_v <= 1'b0;
                        r_alive <= '0;
                        r_st    <= M_INIT;
                    end
                end
                M_INIT: begin
                    if (r_ini_v) begin
                        r_alive[r_ini_idx] <= 1'b1;
                    end
                    if (r_k != r_n) begin
                        r_ini_v   <= 1'b1;
                        r_ini_idx <= r_k[IW-1:0];
                        r_k       <= w_k1;
                    end else begin
                        r_ini_v <= 1'b0;
                        if (!r_ini_v) begin
                            r_i  <= '0;
                            r_fv <= 1'b0;
                            r_sv <= 1'b0;
                            r_st <= (r_live > CW'(1)) ? M_SCAN : M_IDLE;
                        end
                    end
                end
                M_SCAN: begin
                    if (r_i == r_n) begin
                        r_k   <= '0;
                        r_bit <= 1'b0;
                        r_st  <= M_PS;
                    end else if (!r_alive[r_i[IW-1:0]]) begin
                        r_i <= r_i + CW'(1);
                    end else begin
                        r_st <= M_NLD;
                    end
                end
                M_NLD: begin
                    r_cw <= r_wq;
                    r_cl <= r_lq;
                    if (!r_fv) begin
                        r_fv    <= 1'b1;
                        r_first <= r_i[IW-1:0];
                        r_fw    <= r_wq;
                        r_fl    <= r_lq;
                        r_i     <= r_i + CW'(1);
                        r_st    <= M_SCAN;
                    end else begin
                        r_tsec <= 1'b0;
                        r_st   <= M_WCMP;
                    end
                end
                M_WCMP: begin
                    if (r_cw != w_tw) begin
                        r_less <= (r_cw < w_tw);
                        r_st   <= M_RES;
                    end else begin
                        r_k  <= '0;
                        r_st <= M_CH;
                    end
                end
                M_CH: begin
                    if (r_sa.ch != r_sb.ch) begin
                        r_less <= (r_sa.ch < r_sb.ch);
                        r_st   <= M_RES;
                    end else if (w_k1 == w_m) begin
                        r_less <= (r_cl < w_tl);
                        r_st   <= M_RES;
                    end else begin
                        r_k <= w_k1;
                    end
                end
                M_RES: begin
                    r_st <= M_SCAN;
                    r_i  <= r_i + CW'(1);
                    if (!r_tsec && r_less) begin
                        r_sv     <= 1'b1;
                        r_second <= r_first;
                        r_sw     <= r_fw;
                        r_sl     <= r_fl;
                        r_first  <= r_i[IW-1:0];
                        r_fw     <= r_cw;
                        r_fl     <= r_cl;
                    end else if ((!r_tsec && !r_sv) || (r_tsec && r_less)) begin
                        r_sv     <= 1'b1;
                        r_second <= r_i[IW-1:0];
                        r_sw     <= r_cw;
                        r_sl     <= r_cl;
                    end else if (!r_tsec) begin
                        r_tsec <= 1'b1;
                        r_i    <= r_i;
                        r_st   <= M_WCMP;
                    end
                end
                M_PS: r_st <= M_PC;
                M_PC: begin
                    r_leaf <= r_sa.leaf;
                    r_st   <= M_PW;
                end
                M_PW: begin
                    if (w_k1 == w_plen) begin
                        r_k <= '0;
                        if (!r_bit) begin
                            r_bit <= 1'b1;
                            r_st  <= M_PS;
                        end else begin
                            r_st <= M_CR;
                        end
                    end else begin
                        r_k  <= w_k1;
                        r_st <= M_PS;
                    end
                end
                M_CR: r_st <= M_CW;
                M_CW: begin
                    if (w_k1 == r_sl) begin
                        r_st <= M_UPD;
                    end else begin
                        r_k  <= w_k1;
                        r_st <= M_CR;
                    end
                end
                M_UPD: begin
                    r_alive[r_second] <= 1'b0;
                    r_live <= r_live - CW'(1);
                    r_i    <= '0;
                    r_fv   <= 1'b0;
                    r_sv   <= 1'b0;
                    r_st   <= (r_live > CW'(2)) ? M_SCAN : M_IDLE;
                end
                default: r_st <= M_IDLE;
            endcase
        end
    end

    assign o_busy     = (r_st != M_IDLE);
    assign o_tab_addr = r_k[IW-1:0];
    assign o_code     = r_cq;

    a_pair_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == M_PS) |-> (r_first != r_second))
        else $error("merge pair uses one node twice");

    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == M_SCAN) |-> ($countones(r_alive) == int'(r_live)))
        else $error("live node count out of step with alive flags");

endmodule

// File: design/huffman_code_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_builder
// Collects symbol and frequency pairs, sorts them, builds Huffman codes and
// returns one row per sorted symbol with the run totals.
//
//   channel  | direction | handshake                   | beat
//   in       | input     | i_in_valid / o_in_stall     | t_in_beat
//   out      | output    | o_out_valid / i_out_stall   | t_out_beat
//
// Loading takes one pair per cycle; the final pair starts the build.
// Sort: in-place exchange sort on frequency, one compare per inner-loop step.
// Merge: n-1 rounds, each a node scan comparing weights and then node strings
// by character, then code extension for both picked nodes and a string join.
// Rows: a summing pass over the table, then one row at a time, held while stalled.
// Synchronous active-low reset clears control only; input stalls until rows end.
// ----------------------------------------------------------------------------
module huffman_code_builder #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS,
    parameter int FREQ_WIDTH  = hcb_pkg::FREQ_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hcb_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hcb_pkg::t_out_beat o_out_data
);

    localparam int IW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int CW = $clog2(MAX_SYMBOLS + 1);
    localparam int FW = (FREQ_WIDTH < hcb_pkg::FREQ_W) ? FREQ_WIDTH : hcb_pkg::FREQ_W;
    localparam logic [hcb_pkg::FREQ_W-1:0] FREQ_MASK = hcb_pkg::FREQ_W'((64'd1 << FW) - 64'd1);

    localparam logic [2:0] T_LOAD  = 3'd0;
    localparam logic [2:0] T_SORT  = 3'd1;
    localparam logic [2:0] T_MERGE = 3'd2;
    localparam logic [2:0] T_SUM   = 3'd3;
    localparam logic [2:0] T_EMR   = 3'd4;
    localparam logic [2:0] T_EML   = 3'd5;

    logic [2:0]                  r_st;
    logic [CW-1:0]               r_cnt, r_n, r_i;
    logic                        r_sv, r_ov;
    logic [hcb_pkg::TOTAL_W-1:0] r_total;
    hcb_pkg::t_out_beat          r_out;

    logic                        w_accept, w_room, w_sort_start, w_merge_start;
    logic                        w_sort_busy, w_merge_busy;
    logic [IW-1:0]               w_tab_addr, w_merge_tab_addr;
    hcb_pkg::t_entry             w_tab, w_wr_data;
    hcb_pkg::t_code              w_code;
    logic [CW-1:0]               w_n_final;
    logic [hcb_pkg::WBITS_W-1:0] w_wb;
    logic [hcb_pkg::HDR_W-1:0]   w_hdr;
    logic [hcb_pkg::TREE_W-1:0]  w_tree;

    assign w_accept      = i_in_valid && (r_st == T_LOAD);
    assign w_room        = (r_cnt < CW'(MAX_SYMBOLS));
    assign w_n_final     = r_cnt + CW'(w_room);
    assign w_sort_start  = w_accept && i_in_data.final_symbol;
    assign w_merge_start = (r_st == T_SORT) && !w_sort_busy;
    assign w_tab_addr    = (r_st == T_MERGE) ? w_merge_tab_addr : r_i[IW-1:0];
    assign w_wr_data     = '{symbol: i_in_data.symbol,
                             frequency: i_in_data.frequency & FREQ_MASK};

    assign w_wb   = {{(hcb_pkg::WBITS_W - hcb_pkg::FREQ_W){1'b0}}, w_tab.frequency}
                  * {{(hcb_pkg::WBITS_W - hcb_pkg::CLEN_W){1'b0}}, w_code.code_length};
    assign w_hdr  = hcb_pkg::HDR_W'({r_n, 3'b000});
    assign w_tree = hcb_pkg::TREE_W'(r_n - CW'(1));

    hcb_sort #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_sort (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_accept && w_room),
        .i_wr_addr (r_cnt[IW-1:0]),
        .i_wr_data (w_wr_data),
        .i_start   (w_sort_start),
        .i_count   (w_n_final),
        .o_busy    (w_sort_busy),
        .i_rd_addr (w_tab_addr),
        .o_rd_data (w_tab)
    );

    hcb_merge #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_merge_start),
        .i_count     (r_n),
        .o_busy      (w_merge_busy),
        .o_tab_addr  (w_merge_tab_addr),
        .i_tab_data  (w_tab),
        .i_code_addr (r_i[IW-1:0]),
        .o_code      (w_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= T_LOAD;
            r_cnt <= '0;
            r_ov  <= 1'b0;
            r_sv  <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                T_LOAD: begin
                    if (w_accept) begin
                        if (i_in_data.final_symbol) begin
                            r_n   <= w_n_final;
                            r_cnt <= '0;
                            r_st  <= T_SORT;
                        end else if (w_room) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                    end
                end
                T_SORT: begin
                    if (!w_sort_busy) begin
                        r_st <= T_MERGE;
                    end
                end
                T_MERGE: begin
                    if (!w_merge_busy) begin
                        r_i     <= '0;
                        r_sv    <= 1'b0;
                        r_total <= '0;
                        r_st    <= T_SUM;
                    end
                end
                T_SUM: begin
                    if (r_sv) begin
                        r_total <= r_total + hcb_pkg::TOTAL_W'(w_wb);
                    end
                    if (r_i != r_n) begin
                        r_sv <= 1'b1;
                        r_i  <= r_i + CW'(1);
                    end else begin
                        r_sv <= 1'b0;
                        if (!r_sv) begin
                            r_i  <= '0;
                            r_st <= T_EMR;
                        end
                    end
                end
                T_EMR: begin
                    if (!r_ov) begin
                        r_st <= T_EML;
                    end
                end
                T_EML: begin
                    r_ov                     <= 1'b1;
                    r_out.symbol_res         <= w_tab.symbol;
                    r_out.frequency_res      <= w_tab.frequency;
                    r_out.code_bits          <= w_code.code_bits;
                    r_out.code_length        <= w_code.code_length;
                    r_out.weighted_bits      <= w_wb;
                    r_out.total_bits         <= r_total;
                    r_out.header_bits        <= w_hdr;
                    r_out.tree_bits          <= w_tree;
                    r_out.encoded_size       <= r_total + hcb_pkg::TOTAL_W'(w_hdr)
                                                + hcb_pkg::TOTAL_W'(w_tree);
                    r_out.end_of_table       <= (r_i + CW'(1) == r_n);
                    if (r_i + CW'(1) == r_n) begin
                        r_st <= T_LOAD;
                    end else begin
                        r_i  <= r_i + CW'(1);
                        r_st <= T_EMR;
                    end
                end
                default: r_st <= T_LOAD;
            endcase
        end
    end

    assign o_in_stall  = (r_st != T_LOAD);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_row_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> ($past(r_st) == T_EML))
        else $error("output beat raised outside row load");

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the Huffman code builder. Symbol tables of random and directed
// content are loaded beat by beat, and every returned row is checked against
// a behavioural code builder with its own sort and merge.
// ----------------------------------------------------------------------------
module tb;

    localparam int LIMIT = 3000000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    hcb_pkg::t_in_beat  in_data;
    logic               out_valid;
    logic               out_stall;
    hcb_pkg::t_out_beat out_data;

    hcb_pkg::t_in_beat  pending_beats[$];
    hcb_pkg::t_out_beat expected_rows[$];
    int        mismatch_count;
    int        rows_seen;
    int        tables_sent;
    int        cycle_count;
    int        burst_left;
    int        gap_left;
    bit        hold_until_drained;
    bit        stim_done;

    // loader state of the predictor
    logic [7:0]  load_sym[hcb_pkg::MAX_SYMBOLS];
    logic [15:0] load_freq[hcb_pkg::MAX_SYMBOLS];
    int          load_count;

    huffman_code_builder DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic bit node_before(int a, int b, logic [21:0] w[hcb_pkg::MAX_SYMBOLS],
                                       byte unsigned s[hcb_pkg::MAX_SYMBOLS][$]);
        int m;
        if (w[a] != w[b]) return w[a] < w[b];
        m = (s[a].size() < s[b].size()) ? s[a].size() : s[b].size();
        for (int k = 0; k < m; k++)
            if (s[a][k] != s[b][k]) return s[a][k] < s[b][k];
        if (s[a].size() != s[b].size()) return s[a].size() < s[b].size();
        return a < b;
    endfunction

    task automatic build_expected_rows();
        int n;
        int first;
        int second;
        int leaf;
        logic [7:0]   sym[hcb_pkg::MAX_SYMBOLS];
        logic [15:0]  freq[hcb_pkg::MAX_SYMBOLS];
        logic [7:0]   ts;
        logic [15:0]  tf;
        logic [62:0]  code[hcb_pkg::MAX_SYMBOLS];
        int           clen[hcb_pkg::MAX_SYMBOLS];
        logic [21:0]  w[hcb_pkg::MAX_SYMBOLS];
        byte unsigned chars[hcb_pkg::MAX_SYMBOLS][$];
        int           leaves[hcb_pkg::MAX_SYMBOLS][$];
        bit           alive[hcb_pkg::MAX_SYMBOLS];
        longint       total;
        hcb_pkg::t_out_beat row;
        n = load_count;
        for (int i = 0; i < n; i++) begin
            sym[i] = load_sym[i];
            freq[i] = load_freq[i];
        end
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if (freq[j] < freq[i]) begin
                    tf = freq[i]; freq[i] = freq[j]; freq[j] = tf;
                    ts = sym[i]; sym[i] = sym[j]; sym[j] = ts;
                end
        for (int i = 0; i < n; i++) begin
            code[i] = '0;
            clen[i] = 0;
            w[i] = 22'(freq[i]);
            chars[i] = {};
            chars[i].push_back(sym[i]);
            leaves[i] = {};
            leaves[i].push_back(i);
            alive[i] = 1;
        end
        for (int live = n; live > 1; live--) begin
            first = -1;
            second = -1;
            for (int i = 0; i < n; i++) begin
                if (!alive[i]) continue;
                if (first < 0 || node_before(i, first, w, chars)) begin
                    second = first;
                    first = i;
                end else if (second < 0 || node_before(i, second, w, chars)) begin
                    second = i;
                end
            end
            for (int k = 0; k < leaves[first].size(); k++) begin
                leaf = leaves[first][k];
                if (clen[leaf] < 63) clen[leaf]++;
            end
            for (int k = 0; k < leaves[second].size(); k++) begin
                leaf = leaves[second][k];
                if (clen[leaf] < 63) begin
                    code[leaf][clen[leaf]] = 1'b1;
                    clen[leaf]++;
                end
            end
            for (int k = 0; k < chars[second].size(); k++) begin
                chars[first].push_back(chars[second][k]);
                leaves[first].push_back(leaves[second][k]);
            end
            w[first] = w[first] + w[second];
            alive[second] = 0;
        end
        total = 0;
        for (int i = 0; i < n; i++) total += longint'(freq[i]) * clen[i];
        for (int i = 0; i < n; i++) begin
            row.symbol_res    = sym[i];
            row.frequency_res = freq[i];
            row.code_bits     = code[i];
            row.code_length   = hcb_pkg::CLEN_W'(clen[i]);
            row.weighted_bits = hcb_pkg::WBITS_W'(longint'(freq[i]) * clen[i]);
            row.total_bits    = hcb_pkg::TOTAL_W'(total);
            row.header_bits   = hcb_pkg::HDR_W'(n * hcb_pkg::BITS_PER_SYMBOL);
            row.tree_bits     = hcb_pkg::TREE_W'(n - 1);
            row.encoded_size  = hcb_pkg::TOTAL_W'(longint'(n * hcb_pkg::BITS_PER_SYMBOL)
                                                  + total + n - 1);
            row.end_of_table  = (i == n - 1);
            expected_rows.push_back(row);
        end
    endtask

    task automatic predict_beat(hcb_pkg::t_in_beat b);
        if (load_count < hcb_pkg::MAX_SYMBOLS) begin
            load_sym[load_count] = b.symbol;
            load_freq[load_count] = b.frequency;
            load_count++;
        end
        if (b.final_symbol) begin
            build_expected_rows();
            load_count = 0;
        end
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("mismatch row %0d %s: got %0h want %0h", rows_seen, what, got, want);
    endtask

    task automatic queue_table(int n, int fmode, int smode);
        hcb_pkg::t_in_beat b;
        for (int i = 0; i < n; i++) begin
            case (smode)
                0: b.symbol = 8'($urandom_range(0, 255));
                1: b.symbol = 8'(i);
                2: b.symbol = 8'h41;
                default: b.symbol = $urandom_range(0, 1) ? 8'h00 : 8'hff;
            endcase
            case (fmode)
                0: b.frequency = 16'($urandom_range(0, 65535));
                1: b.frequency = 16'($urandom_range(0, 9));
                2: b.frequency = 16'hffff;
                3: b.frequency = 16'd0;
                4: b.frequency = 16'd1 << (i % 16);
                default: b.frequency = $urandom_range(0, 3) == 0 ? 16'hffff : 16'd5;
            endcase
            b.final_symbol = (i == n - 1);
            pending_beats.push_back(b);
        end
        tables_sent++;
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) predict_beat(in_data);
            if (pending_beats.size() == 0 || hold_until_drained) begin
                in_valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else begin
                in_valid <= 1'b1;
                in_data <= pending_beats.pop_front();
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_rows.size() == 0) begin
                    report("unexpected row", 64'(out_data.symbol_res), 64'd0);
                end else begin
                    hcb_pkg::t_out_beat e;
                    e = expected_rows.pop_front();
                    if (out_data.symbol_res !== e.symbol_res)
                        report("symbol", 64'(out_data.symbol_res), 64'(e.symbol_res));
                    if (out_data.frequency_res !== e.frequency_res)
                        report("frequency", 64'(out_data.frequency_res),
                               64'(e.frequency_res));
                    if (out_data.code_bits !== e.code_bits)
                        report("code", 64'(out_data.code_bits), 64'(e.code_bits));
                    if (out_data.code_length !== e.code_length)
                        report("length", 64'(out_data.code_length), 64'(e.code_length));
                    if (out_data.weighted_bits !== e.weighted_bits)
                        report("weighted", 64'(out_data.weighted_bits),
                               64'(e.weighted_bits));
                    if (out_data.total_bits !== e.total_bits)
                        report("total", 64'(out_data.total_bits), 64'(e.total_bits));
                    if (out_data.header_bits !== e.header_bits)
                        report("header", 64'(out_data.header_bits), 64'(e.header_bits));
                    if (out_data.tree_bits !== e.tree_bits)
                        report("tree", 64'(out_data.tree_bits), 64'(e.tree_bits));
                    if (out_data.encoded_size !== e.encoded_size)
                        report("size", 64'(out_data.encoded_size), 64'(e.encoded_size));
                    if (out_data.end_of_table !== e.end_of_table)
                        report("end", 64'(out_data.end_of_table), 64'(e.end_of_table));
                end
                rows_seen <= rows_seen + 1;
            end
            case ((cycle_count / 500) % 3)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        mismatch_count = 0;
        rows_seen = 0;
        tables_sent = 0;
        cycle_count = 0;
        load_count = 0;
        hold_until_drained = 1'b0;
        stim_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed tables
        queue_table(1, 2, 3);
        queue_table(2, 3, 3);
        queue_table(3, 1, 2);
        queue_table(5, 4, 1);
        queue_table(4, 5, 0);
        queue_table(6, 2, 0);
        while (pending_beats.size() > 0 || in_valid) @(posedge clk);
        hold_until_drained = 1'b1;
        while (expected_rows.size() > 0) @(posedge clk);
        hold_until_drained = 1'b0;

        // full table and an overfilled one
        queue_table(64, 0, 0);
        queue_table(70, 1, 3);

        // random tables, mostly small
        while (pending_beats.size() < 180) begin
            int n;
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 10);
            queue_table(n, $urandom_range(0, 5), $urandom_range(0, 3));
        end
        while (pending_beats.size() > 0 || in_valid) @(posedge clk);
        while (expected_rows.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("%0d tables loaded, %0d rows checked, sizes from 1 to over 64 symbols",
                 tables_sent, rows_seen);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: filelist.f
design/hcb_pkg.sv
design/hcb_sort.sv
design/hcb_merge.sv
design/huffman_code_builder.sv
tb/sv/tb.sv
